// ===== design/tcw_pkg.sv =====
// Text console writer: shared constants, types and helpers.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int SWEEP_W   = $clog2(COLUMNS + 1);
  localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

  // Transaction field widths
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int CELL_W    = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_OFF_W = 11;
  localparam int S_PAD_W   = 5;
  localparam int M_PAD_W   = 1;
  localparam int S_TDATA_W = S_PAD_W + CELL_W + CHAR_W;
  localparam int M_TDATA_W = M_PAD_W + 2 * CHAR_W + OUT_OFF_W + OUT_ROW_W + OUT_COL_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_NL,
    CUR_CR
  } cur_op_e;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] off;       // linear cursor position
    logic [ADDR_W-1:0] top;       // physical base of logical row 0
    logic [ADDR_W-1:0] phys;      // physical address of the cursor cell
    logic [ADDR_W-1:0] src_base;  // physical base of the bottom row
    logic              scroll;    // current op pushes past the last row
  } cur_stat_t;

  typedef struct packed {
    logic              we_char;
    logic              we_colour;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wchar;
    logic [CHAR_W-1:0] wcolour;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    logic hit;
  } res_ctl_t;

  typedef struct packed {
    logic [S_PAD_W-1:0] pad;
    logic [CELL_W-1:0]  cell_index;
    logic [CHAR_W-1:0]  char_code;
  } s_data_t;

  typedef struct packed {
    logic [M_PAD_W-1:0]   pad;
    logic [CHAR_W-1:0]    read_colour;
    logic [CHAR_W-1:0]    read_char;
    logic [OUT_OFF_W-1:0] cursor_offset;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
  } m_data_t;

  // Add two cell offsets modulo the screen size (both below CELLS)
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W + 1)'(CELLS)) begin
      sum = sum - (ADDR_W + 1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/text_console_writer_top.sv =====
// Text console writer, top level: stream ports, colour register, result register.
// Depends on tcw_pkg, tcw_store, tcw_cursor and tcw_seq.
//
// An 80x25 text console. Each input transaction is a put (one byte), a clear or
// a read of one cell, and gives exactly one result transaction with the cursor
// after the request and, for a read, the cell's character and attribute. The
// block works on one transaction at a time; a finished result waits in an
// output register, so the next request is taken while it is still unread.
// The screen scrolls by rotating a top-row pointer, and only the new bottom
// row is rewritten (characters to NUL, attributes copied from the old bottom
// row). A put or read goes through accept, memory access and result; a tab
// writes its spaces one after another, and a clear rewrites every cell, one
// cell per cycle. After reset a clearing pass over all CELLS = 2000 cells
// fills the memories with NUL and attribute 0x07, during which s_axis_tready
// stays low; the colour register can be written meanwhile. The colour
// register should only be written while the block is idle.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: clear colour
  input  logic                 cfg_we_i,
  input  logic [CHAR_W-1:0]    cfg_wdata_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // cursor_col[6:0], cursor_row[11:7],
                                               // cursor_offset[22:12], read_char[30:23],
                                               // read_colour[38:31], zero pad
);

  s_data_t           s_data;
  m_data_t           m_data_d, m_data_q;
  logic              m_tvalid_q, m_tvalid_d;
  logic [CHAR_W-1:0] clear_colour_q;
  cur_stat_t         cur_stat;
  cur_op_e           cur_op;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] rchar, rcolour;
  res_ctl_t          res_ctl;
  logic              out_free;

  assign s_data   = s_data_t'(s_axis_tdata);
  assign out_free = !m_tvalid_q || m_axis_tready;

  // clear colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_colour_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      clear_colour_q <= cfg_wdata_i;
    end
  end

  tcw_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rchar_o   (rchar),
    .rcolour_o (rcolour)
  );

  tcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (cur_op),
    .stat_o (cur_stat)
  );

  tcw_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .char_code_i    (s_data.char_code),
    .cell_index_i   (s_data.cell_index),
    .clear_colour_i (clear_colour_q),
    .cur_i          (cur_stat),
    .cur_op_o       (cur_op),
    .mem_o          (mem_req),
    .rcolour_i      (rcolour),
    .out_free_i     (out_free),
    .res_o          (res_ctl)
  );

  // result register: loaded once the request has fully finished
  always_comb begin
    m_data_d.pad           = '0;
    m_data_d.read_colour   = res_ctl.hit ? rcolour : CH_NUL;
    m_data_d.read_char     = res_ctl.hit ? rchar : CH_NUL;
    m_data_d.cursor_offset = OUT_OFF_W'(cur_stat.off);
    m_data_d.cursor_row    = OUT_ROW_W'(cur_stat.row);
    m_data_d.cursor_col    = OUT_COL_W'(cur_stat.col);
    m_tvalid_d             = res_ctl.load ? 1'b1 : (m_axis_tready ? 1'b0 : m_tvalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ctl.load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_data_q);

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.load |-> (!m_tvalid_q || m_axis_tready))
    else $error("result loaded over an unread result");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_stat.off) == int'(cur_stat.row) * COLUMNS + int'(cur_stat.col))
    else $error("cursor offset out of step with row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cur_stat.col) < COLUMNS) && (int'(cur_stat.row) < ROWS))
    else $error("cursor outside the screen");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in progress");
`endif

endmodule

// ===== design/tcw_store.sv =====
// Character and attribute memories, one write and one read port each.
// Depends on tcw_pkg.
module tcw_store
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [CHAR_W-1:0] rchar_o,
  output logic [CHAR_W-1:0] rcolour_o
);

  logic [CHAR_W-1:0] char_mem   [CELLS];
  logic [CHAR_W-1:0] colour_mem [CELLS];
  logic [CHAR_W-1:0] rchar_q;
  logic [CHAR_W-1:0] rcolour_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we_char) begin
      char_mem[req_i.waddr] <= req_i.wchar;
    end
    if (req_i.we_colour) begin
      colour_mem[req_i.waddr] <= req_i.wcolour;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rchar_q   <= char_mem[req_i.raddr];
      rcolour_q <= colour_mem[req_i.raddr];
    end
  end

  assign rchar_o   = rchar_q;
  assign rcolour_o = rcolour_q;

endmodule

// ===== design/tcw_cursor.sv =====
// Cursor column, row, linear offset and rotating top-row base.
// Depends on tcw_pkg.
module tcw_cursor
  import tcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cur_op_e   op_i,
  output cur_stat_t stat_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [ADDR_W-1:0] top_q, top_d;
  logic              last_col;
  logic              last_row;
  logic              scroll;
  logic [ADDR_W-1:0] top_next;

  assign last_col = (col_q == COL_W'(COLUMNS - 1));
  assign last_row = (row_q == ROW_W'(ROWS - 1));
  assign scroll   = last_row && (((op_i == CUR_ADV) && last_col) || (op_i == CUR_NL));
  // the old top row becomes the new bottom row
  assign top_next = (top_q == ADDR_W'(CELLS - COLUMNS)) ? '0 : top_q + ADDR_W'(COLUMNS);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    off_d = off_q;
    top_d = top_q;
    case (op_i)
      CUR_ADV: begin
        if (!last_col) begin
          col_d = col_q + 1'b1;
          off_d = off_q + 1'b1;
        end else if (!last_row) begin
          col_d = '0;
          row_d = row_q + 1'b1;
          off_d = off_q + 1'b1;
        end else begin
          col_d = '0;
          off_d = off_q - ADDR_W'(COLUMNS - 1);
          top_d = top_next;
        end
      end
      CUR_NL: begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + 1'b1;
          off_d = off_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
        end else begin
          off_d = off_q - ADDR_W'(col_q);
          top_d = top_next;
        end
      end
      CUR_CR: begin
        col_d = '0;
        off_d = off_q - ADDR_W'(col_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      off_q <= '0;
      top_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      off_q <= off_d;
      top_q <= top_d;
    end
  end

  always_comb begin
    stat_o.col      = col_q;
    stat_o.row      = row_q;
    stat_o.off      = off_q;
    stat_o.top      = top_q;
    stat_o.phys     = wrap_add(off_q, top_q);
    stat_o.src_base = (top_q == '0) ? ADDR_W'((ROWS - 1) * COLUMNS)
                                    : top_q - ADDR_W'(COLUMNS);
    stat_o.scroll   = scroll;
  end

endmodule

// ===== design/tcw_seq.sv =====
// Request sequencer: put, tab, scroll, clear and read sweeps over the memories.
// Depends on tcw_pkg; drives tcw_store and tcw_cursor.
module tcw_seq
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [CELL_W-1:0] cell_index_i,
  input  logic [CHAR_W-1:0] clear_colour_i,
  input  cur_stat_t         cur_i,
  output cur_op_e           cur_op_o,
  output mem_req_t          mem_o,
  input  logic [CHAR_W-1:0] rcolour_i,
  input  logic              out_free_i,
  output res_ctl_t          res_o
);

  state_e                state_q, state_d;
  logic [REQ_W-1:0]      req_q, req_d;
  logic [CHAR_W-1:0]     ch_q, ch_d;
  logic [CELL_W-1:0]     cell_q, cell_d;
  logic                  in_range_q, in_range_d;
  logic [TAB_CNT_W-1:0]  tab_left_q, tab_left_d;
  logic [SWEEP_W-1:0]    sweep_q, sweep_d;
  logic [ADDR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic                  is_nl, is_cr, is_tab;
  logic                  sweep_end, fill_end;

  assign is_nl     = (ch_q == CH_NL);
  assign is_cr     = (ch_q == CH_CR);
  assign is_tab    = (ch_q == CH_TAB);
  assign sweep_end = (sweep_q == SWEEP_W'(COLUMNS));
  assign fill_end  = (wr_ptr_q == ADDR_W'(CELLS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (fill_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_PUT:   state_d = ST_PUT;
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        if (cur_i.scroll) begin
          state_d = ST_SCROLL;
        end else if (is_tab && (tab_left_q != TAB_CNT_W'(1))) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (sweep_end) begin
          state_d = (is_tab && (tab_left_q != '0)) ? ST_PUT : ST_DONE;
        end
      end
      ST_CLEAR: begin
        if (fill_end) state_d = ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cur_op_o   = CUR_HOLD;
    mem_o      = '0;
    res_o      = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_o.we_char   = 1'b1;
        mem_o.we_colour = 1'b1;
        mem_o.waddr     = wr_ptr_q;
        mem_o.wchar     = CH_NUL;
        mem_o.wcolour   = ATTR_RESET;
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_PUT: begin
        if (is_nl) begin
          cur_op_o = CUR_NL;
        end else if (is_cr) begin
          cur_op_o = CUR_CR;
        end else begin
          cur_op_o      = CUR_ADV;
          mem_o.we_char = 1'b1;
          mem_o.waddr   = cur_i.phys;
          mem_o.wchar   = is_tab ? CH_SPACE : ch_q;
        end
      end
      ST_SCROLL: begin
        // read the bottom row's attributes one cell ahead of the write
        mem_o.re        = !sweep_end;
        mem_o.raddr     = rd_ptr_q;
        mem_o.we_char   = (sweep_q != '0);
        mem_o.we_colour = (sweep_q != '0);
        mem_o.waddr     = wr_ptr_q;
        mem_o.wchar     = CH_NUL;
        mem_o.wcolour   = rcolour_i;
      end
      ST_CLEAR: begin
        mem_o.we_char   = 1'b1;
        mem_o.we_colour = 1'b1;
        mem_o.waddr     = wr_ptr_q;
        mem_o.wchar     = CH_NUL;
        mem_o.wcolour   = clear_colour_i;
      end
      ST_READ: begin
        mem_o.re    = in_range_q;
        mem_o.raddr = wrap_add(ADDR_W'(cell_q), cur_i.top);
      end
      ST_DONE: begin
        res_o.load = out_free_i;
        res_o.hit  = (req_q == REQ_READ) && in_range_q;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    req_d      = req_q;
    ch_d       = ch_q;
    cell_d     = cell_q;
    in_range_d = in_range_q;
    tab_left_d = tab_left_q;
    sweep_d    = sweep_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = req_type_i;
          ch_d       = char_code_i;
          cell_d     = cell_index_i;
          in_range_d = (int'(cell_index_i) < CELLS);
          tab_left_d = TAB_CNT_W'(TAB_WIDTH) - TAB_CNT_W'(cur_i.col % TAB_WIDTH);
          wr_ptr_d   = '0;
        end
      end
      ST_PUT: begin
        if (is_tab) tab_left_d = tab_left_q - 1'b1;
        if (cur_i.scroll) begin
          wr_ptr_d = cur_i.top;
          rd_ptr_d = cur_i.src_base;
          sweep_d  = '0;
        end
      end
      ST_SCROLL: begin
        sweep_d  = sweep_q + 1'b1;
        rd_ptr_d = rd_ptr_q + 1'b1;
        if (sweep_q != '0) wr_ptr_d = wr_ptr_q + 1'b1;
      end
      ST_INIT, ST_CLEAR: wr_ptr_d = wr_ptr_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      wr_ptr_q   <= '0;
      tab_left_q <= '0;
      sweep_q    <= '0;
      in_range_q <= 1'b0;
      req_q      <= REQ_PUT;
    end else begin
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      tab_left_q <= tab_left_d;
      sweep_q    <= sweep_d;
      in_range_q <= in_range_d;
      req_q      <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    cell_q   <= cell_d;
    rd_ptr_q <= rd_ptr_d;
  end

endmodule
